// File: rtl/hinted_optimal_block_cache_policy_core_defines.svh
// Assertion macros used by the checker file.
`ifndef HINTED_OPTIMAL_BLOCK_CACHE_POLICY_CORE_DEFINES_SVH
`define HINTED_OPTIMAL_BLOCK_CACHE_POLICY_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define HOBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define HOBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/hobc_pkg.sv
// Shared types and constants of the hinted optimal block cache policy core.
package hobc_pkg;
  localparam int CacheSlots = 64;
  localparam int HintSlots  = 2048;
  localparam int SlotW      = $clog2(CacheSlots);
  localparam int HintW      = $clog2(HintSlots);
  localparam logic [31:0] Never = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_ADVICE = 2'd2,
    ACT_FLUSH  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HSCAN,
    ST_HWAIT,
    ST_PSCAN,
    ST_PWAIT,
    ST_DECIDE,
    ST_WBOUT,
    ST_FILL,
    ST_FSCAN,
    ST_FWAIT,
    ST_FTAIL,
    ST_CLEAR
  } state_t;

  // One result transaction as produced by the controller.
  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic              fill;
    logic              writeback;
    logic [31:0]       writeback_block;
    logic              last;
  } result_t;

  typedef struct packed {
    logic             we;
    logic             valid;
    logic [HintW-1:0] addr;
    logic [31:0]      tag;
    logic [31:0]      tval;
  } hint_wr_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    logic             valid;
    logic             dirty;
    logic [31:0]      tag;
    logic [31:0]      reuse;
  } page_wr_t;
endpackage

// File: rtl/hinted_optimal_block_cache_policy_core.sv
// Top level of the hinted optimal block cache policy core.
// Tag-only policy engine for a fully associative block cache.
// Input: present in_action, in_blk and in_hint with start; the transaction
// is taken at a clock edge where start is high and busy is low.
// Results appear on the out_ ports for one cycle, marked by out_valid, with
// out_last set on the final result of each transaction.
// Accesses and advice scan the 2048-entry hint memory (one entry a cycle)
// and then the 64-slot page store, through the single read port of each
// memory; busy stays high through the scans, their wait states and
// ST_DECIDE, and through ST_WBOUT too when a dirty page is evicted. The
// result comes in ST_DECIDE, or the write-back there and the fill in
// ST_WBOUT. A new transaction is taken once busy is low again.
// A flush scans the page store only, adding ST_FTAIL when the last slot is
// dirty, and gives one result per dirty page, each reported one behind.
// After reset the hint memory is cleared, one entry a cycle, over all 2048
// entries, during which busy stays high.
// The receiver cannot stall: every result must be taken when shown.
module hinted_optimal_block_cache_policy_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_blk,
  input  logic [31:0] in_hint,
  output logic        out_valid,
  output logic        out_hit,
  output logic [5:0]  out_slot,
  output logic        out_fill,
  output logic        out_writeback,
  output logic [31:0] out_writeback_block,
  output logic        out_last
);
  import hobc_pkg::*;

  logic [HintW-1:0] h_rd_addr;
  logic             h_clr;
  logic             h_rd_valid;
  logic [31:0]      h_rd_tag, h_rd_time;
  hint_wr_t         h_wr, h_wr_mem;
  logic [SlotW-1:0] p_rd_addr;
  logic             p_rd_valid, p_rd_dirty;
  logic [31:0]      p_rd_tag, p_rd_reuse;
  page_wr_t         p_wr;
  logic             res_strobe;
  result_t          res;

  hobc_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_action, .in_blk, .in_hint,
    .h_rd_addr, .h_clr, .h_rd_valid, .h_rd_tag, .h_rd_time, .h_wr,
    .p_rd_addr, .p_rd_valid, .p_rd_dirty, .p_rd_tag, .p_rd_reuse, .p_wr,
    .res_strobe, .res
  );

  // The clearing pass writes each entry with its valid bit low.
  always_comb begin
    h_wr_mem = h_wr;
    if (h_clr) begin
      h_wr_mem.we    = 1'b1;
      h_wr_mem.valid = 1'b0;
      h_wr_mem.addr  = h_rd_addr;
      h_wr_mem.tag   = '0;
      h_wr_mem.tval  = '0;
    end
  end

  hobc_hint_mem u_hint (
    .clk, .rd_addr(h_rd_addr), .wr(h_wr_mem), .rd_valid(h_rd_valid),
    .rd_tag(h_rd_tag), .rd_time(h_rd_time)
  );

  hobc_page_mem u_page (
    .clk, .rst_n, .rd_addr(p_rd_addr), .wr(p_wr), .rd_valid(p_rd_valid),
    .rd_dirty(p_rd_dirty), .rd_tag(p_rd_tag), .rd_reuse(p_rd_reuse)
  );

  assign out_valid           = res_strobe;
  assign out_hit             = res.hit;
  assign out_slot            = 6'(res.slot);
  assign out_fill            = res.fill;
  assign out_writeback       = res.writeback;
  assign out_writeback_block = res.writeback_block;
  assign out_last            = res.last;
endmodule

// File: rtl/hobc_hint_mem.sv
// Hint table memory: valid bit, block tag and next-use time per entry.
module hobc_hint_mem (
  input  logic                    clk,
  input  logic [hobc_pkg::HintW-1:0] rd_addr,
  input  hobc_pkg::hint_wr_t      wr,
  output logic                    rd_valid,
  output logic [31:0]             rd_tag,
  output logic [31:0]             rd_time
);
  import hobc_pkg::*;

  logic [64:0] mem [HintSlots];
  logic [64:0] q_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= {wr.valid, wr.tag, wr.tval};
    end
    q_r <= mem[rd_addr];
  end

  // Cleared entries are written with the valid bit low by the clearing pass.
  assign rd_valid = q_r[64];
  assign rd_tag   = q_r[63:32];
  assign rd_time  = q_r[31:0];
endmodule

// File: rtl/hobc_page_mem.sv
// Page store memory: valid, dirty, tag and next-use per cache slot.
module hobc_page_mem (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [hobc_pkg::SlotW-1:0] rd_addr,
  input  hobc_pkg::page_wr_t      wr,
  output logic                    rd_valid,
  output logic                    rd_dirty,
  output logic [31:0]             rd_tag,
  output logic [31:0]             rd_reuse
);
  import hobc_pkg::*;

  logic [63:0] mem [CacheSlots];
  logic [63:0] q_r;
  logic [CacheSlots-1:0] valid_r;
  logic [CacheSlots-1:0] dirty_r;
  logic [SlotW-1:0] rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= {wr.tag, wr.reuse};
    end
    q_r       <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.addr] <= wr.valid;
      dirty_r[wr.addr] <= wr.dirty;
    end
  end

  assign rd_valid = valid_r[rd_addr_r];
  assign rd_dirty = dirty_r[rd_addr_r];
  assign rd_tag   = q_r[63:32];
  assign rd_reuse = q_r[31:0];
endmodule

// File: rtl/hobc_ctrl.sv
// Sequencer scanning the hint table and page store; a flush scans the page store only.
module hobc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic [31:0]                in_blk,
  input  logic [31:0]                in_hint,
  output logic [hobc_pkg::HintW-1:0] h_rd_addr,
  output logic                       h_clr,
  input  logic                       h_rd_valid,
  input  logic [31:0]                h_rd_tag,
  input  logic [31:0]                h_rd_time,
  output hobc_pkg::hint_wr_t         h_wr,
  output logic [hobc_pkg::SlotW-1:0] p_rd_addr,
  input  logic                       p_rd_valid,
  input  logic                       p_rd_dirty,
  input  logic [31:0]                p_rd_tag,
  input  logic [31:0]                p_rd_reuse,
  output hobc_pkg::page_wr_t         p_wr,
  output logic                       res_strobe,
  output hobc_pkg::result_t          res
);
  import hobc_pkg::*;

  localparam logic [HintW-1:0] HLast = HintW'(HintSlots - 1);
  localparam logic [SlotW-1:0] PLast = SlotW'(CacheSlots - 1);

  state_t state_r, state_nxt;
  logic [1:0]       act_r;
  logic [31:0]      blk_r, hint_r;
  logic [HintW-1:0] hidx_r, hidx_nxt;
  logic [SlotW-1:0] pidx_r, pidx_nxt;
  // Hint scan results.
  logic             hfound_r, hfree_r;
  logic [HintW-1:0] hmatch_r, hfree_idx_r;
  logic [31:0]      htime_r;
  // Page scan results.
  logic             pfound_r, pfree_r, pbest_any_r;
  logic [SlotW-1:0] pmatch_r, pfree_idx_r, pbest_r;
  logic [31:0]      pbest_val_r, pbest_tag_r;
  logic             pbest_dirty_r, pm_dirty_r;
  logic             fany_r;
  logic [SlotW-1:0] flast_r;
  logic [31:0]      flast_tag_r;
  logic             hscan_end, pscan_end;
  logic             f_dirty_now;

  assign busy = (state_r != ST_IDLE);
  assign hscan_end = (hidx_r == HLast);
  assign pscan_end = (pidx_r == PLast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      hidx_r  <= '0;
      pidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      hidx_r  <= hidx_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    hidx_nxt  = hidx_r;
    pidx_nxt  = pidx_r;
    case (state_r)
      ST_CLEAR: begin
        hidx_nxt = hidx_r + 1'b1;
        if (hscan_end) begin
          state_nxt = ST_IDLE;
          hidx_nxt  = '0;
        end
      end
      ST_IDLE: begin
        hidx_nxt = '0;
        pidx_nxt = '0;
        if (start) begin
          state_nxt = (action_t'(in_action) == ACT_FLUSH) ? ST_FSCAN : ST_HSCAN;
        end
      end
      ST_HSCAN: begin
        hidx_nxt = hidx_r + 1'b1;
        if (hscan_end) begin
          state_nxt = ST_HWAIT;
        end
      end
      ST_HWAIT:  state_nxt = ST_PSCAN;
      ST_PSCAN: begin
        pidx_nxt = pidx_r + 1'b1;
        if (pscan_end) begin
          state_nxt = ST_PWAIT;
        end
      end
      ST_PWAIT:  state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (act_r == ACT_ADVICE || pfound_r || pfree_r || !pbest_dirty_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_WBOUT;
        end
      end
      ST_WBOUT:  state_nxt = ST_IDLE;
      ST_FSCAN: begin
        pidx_nxt = pidx_r + 1'b1;
        if (pscan_end) begin
          state_nxt = ST_FWAIT;
        end
      end
      // A dirty final slot is still owed its result, given in ST_FTAIL after the wait state.
      ST_FWAIT:  state_nxt = f_dirty_now ? ST_FTAIL : ST_IDLE;
      ST_FTAIL:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign h_rd_addr = hidx_r;
  assign p_rd_addr = pidx_r;
  assign h_clr     = (state_r == ST_CLEAR);

  // Scan bookkeeping; memory data for an address arrives in the next cycle.
  logic h_cmp_r, p_cmp_r, f_cmp_r;
  logic [HintW-1:0] h_cmp_idx_r;
  logic [SlotW-1:0] p_cmp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_cmp_r <= 1'b0;
      p_cmp_r <= 1'b0;
      f_cmp_r <= 1'b0;
    end else begin
      h_cmp_r <= (state_r == ST_HSCAN);
      p_cmp_r <= (state_r == ST_PSCAN);
      f_cmp_r <= (state_r == ST_FSCAN);
    end
    h_cmp_idx_r <= hidx_r;
    p_cmp_idx_r <= pidx_r;
  end

  logic h_hit_now, p_hit_now;
  assign h_hit_now   = h_rd_valid && (h_rd_tag == blk_r);
  assign p_hit_now   = p_rd_valid && (p_rd_tag == blk_r);
  assign f_dirty_now = f_cmp_r && p_rd_valid && p_rd_dirty;

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      act_r       <= in_action;
      blk_r       <= in_blk;
      hint_r      <= in_hint;
      hfound_r    <= 1'b0;
      hfree_r     <= 1'b0;
      hfree_idx_r <= HLast;
      htime_r     <= Never;
      pfound_r    <= 1'b0;
      pfree_r     <= 1'b0;
      pbest_any_r <= 1'b0;
      fany_r      <= 1'b0;
    end
    if (h_cmp_r) begin
      if (h_hit_now && !hfound_r) begin
        hfound_r <= 1'b1;
        hmatch_r <= h_cmp_idx_r;
        htime_r  <= h_rd_time;
      end
      if (!h_rd_valid && !hfree_r) begin
        hfree_r     <= 1'b1;
        hfree_idx_r <= h_cmp_idx_r;
      end
    end
    if (p_cmp_r) begin
      if (p_hit_now && !pfound_r) begin
        pfound_r   <= 1'b1;
        pmatch_r   <= p_cmp_idx_r;
        pm_dirty_r <= p_rd_dirty;
      end
      if (!p_rd_valid && !pfree_r) begin
        pfree_r     <= 1'b1;
        pfree_idx_r <= p_cmp_idx_r;
      end
      if (!pbest_any_r || p_rd_reuse >= pbest_val_r) begin
        pbest_any_r   <= 1'b1;
        pbest_val_r   <= p_rd_reuse;
        pbest_r       <= p_cmp_idx_r;
        pbest_tag_r   <= p_rd_tag;
        pbest_dirty_r <= p_rd_dirty;
      end
    end
    if (f_dirty_now) begin
      fany_r      <= 1'b1;
      flast_r     <= p_cmp_idx_r;
      flast_tag_r <= p_rd_tag;
    end
  end

  logic [SlotW-1:0] ins_slot;
  logic [31:0]      new_use;
  assign ins_slot = pfree_r ? pfree_idx_r : pbest_r;
  assign new_use  = hfound_r ? htime_r : Never;

  // Outputs and write-backs into both memories.
  always_comb begin
    h_wr       = '0;
    p_wr       = '0;
    res_strobe = 1'b0;
    res        = '0;
    case (state_r)
      ST_CLEAR: begin
        h_wr.we   = 1'b0;
      end
      ST_DECIDE: begin
        if (act_r == ACT_ADVICE) begin
          h_wr.we    = 1'b1;
          h_wr.valid = 1'b1;
          h_wr.addr  = hfound_r ? hmatch_r : hfree_idx_r;
          h_wr.tag   = blk_r;
          h_wr.tval  = hint_r;
          res_strobe = 1'b1;
          res.last   = 1'b1;
          if (pfound_r) begin
            res.hit    = 1'b1;
            res.slot   = pmatch_r;
            p_wr.we    = 1'b1;
            p_wr.addr  = pmatch_r;
            p_wr.valid = 1'b1;
            p_wr.dirty = pm_dirty_r;
            p_wr.tag   = blk_r;
            p_wr.reuse = hint_r;
          end
        end else if (pfound_r) begin
          res_strobe = 1'b1;
          res.hit    = 1'b1;
          res.slot   = pmatch_r;
          res.last   = 1'b1;
          p_wr.we    = 1'b1;
          p_wr.addr  = pmatch_r;
          p_wr.valid = 1'b1;
          p_wr.dirty = pm_dirty_r | (act_r == ACT_WRITE);
          p_wr.tag   = blk_r;
          p_wr.reuse = new_use;
        end else if (!pfree_r && pbest_dirty_r) begin
          res_strobe          = 1'b1;
          res.slot            = pbest_r;
          res.writeback       = 1'b1;
          res.writeback_block = pbest_tag_r;
        end else begin
          res_strobe = 1'b1;
          res.slot   = ins_slot;
          res.fill   = 1'b1;
          res.last   = 1'b1;
          p_wr.we    = 1'b1;
          p_wr.addr  = ins_slot;
          p_wr.valid = 1'b1;
          p_wr.dirty = (act_r == ACT_WRITE);
          p_wr.tag   = blk_r;
          p_wr.reuse = new_use;
        end
      end
      ST_WBOUT: begin
        res_strobe = 1'b1;
        res.slot   = pbest_r;
        res.fill   = 1'b1;
        res.last   = 1'b1;
        p_wr.we    = 1'b1;
        p_wr.addr  = pbest_r;
        p_wr.valid = 1'b1;
        p_wr.dirty = (act_r == ACT_WRITE);
        p_wr.tag   = blk_r;
        p_wr.reuse = new_use;
      end
      default: begin
        res_strobe = 1'b0;
      end
    endcase
    // Flush: each dirty page found is written back clean and reported one result
    // behind, so that the final one can carry the last mark.
    if ((state_r == ST_FSCAN || state_r == ST_FWAIT) && f_dirty_now) begin
      p_wr.we    = 1'b1;
      p_wr.addr  = p_cmp_idx_r;
      p_wr.valid = 1'b1;
      p_wr.dirty = 1'b0;
      p_wr.tag   = p_rd_tag;
      p_wr.reuse = p_rd_reuse;
    end
    if ((state_r == ST_FSCAN && f_dirty_now && fany_r) ||
        (state_r == ST_FWAIT && fany_r) || (state_r == ST_FTAIL)) begin
      res_strobe          = 1'b1;
      res.slot            = flast_r;
      res.writeback       = 1'b1;
      res.writeback_block = flast_tag_r;
      res.last            = (state_r == ST_FTAIL) ||
                            ((state_r == ST_FWAIT) && !f_dirty_now);
    end
  end
endmodule

// File: rtl/hobc_checker.sv
// Port-level checker for the hinted optimal block cache policy core.
`include "hinted_optimal_block_cache_policy_core_defines.svh"
module hobc_assert_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_fill,
  input logic        out_hit,
  input logic        out_writeback,
  input logic        out_last
);
  `HOBC_ASSERT_IMP(a_fill_not_hit, clk, rst_n, out_valid && out_fill,
                   !out_hit && !out_writeback, "fill with hit or writeback")
  `HOBC_ASSERT_IMP(a_result_busy, clk, rst_n, out_valid && !out_last, busy,
                   "result mid-transaction while idle")
  `HOBC_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy,
                    "transaction taken but not busy")
endmodule

bind hinted_optimal_block_cache_policy_core hobc_assert_checker u_hobc_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_fill, .out_hit, .out_writeback, .out_last
);
